>>> sv/lct_pkg.sv
// Shared constants, types and helpers for the LRU eviction tracker.
package lct_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_BITS   = 20;
  localparam int COUNT_BITS  = 32;

  localparam int CAP_W   = 7;
  localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SQ_W    = 2 * COUNT_BITS;
  localparam int SUM_W   = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 344;
  localparam int OUT_TUSER_W = 2;

  // one directory slot
  typedef struct packed {
    logic                  valid;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] enter;
    logic [COUNT_BITS-1:0] refs;
  } lct_entry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                 cmp;
    logic [ADDR_BITS-1:0] cmp_addr;
    logic                 upd;
    logic                 hit;
    logic                 evict;
    logic [IDX_W-1:0]     top;
    lct_entry_t           fresh;
  } lct_ctl_t;

  // result beat, lowest field last
  typedef struct packed {
    logic [3:0]  pad;
    logic [63:0] age_square_sum;
    logic [63:0] age_sum;
    logic [31:0] evict_total;
    logic [31:0] fill_mark;
    logic [31:0] miss_total;
    logic [31:0] access_total;
    logic [31:0] age_since_entry;
    logic [31:0] age_since_reference;
    logic [19:0] evicted_address;
  } lct_out_t;

  function automatic logic [COUNT_BITS-1:0] lct_sat_inc(input logic [COUNT_BITS-1:0] v);
    lct_sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [SUM_W-1:0] lct_sat_add(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    lct_sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

>>> sv/lru_cache_eviction_tracker.sv
// Each access runs through accept and compare, chain update, square, then sum and result.
// Ready only in idle, so a new beat is taken only once the last one's result is registered.
// The result is registered in the sum step; a held result stalls the final step.
// Reset (async) clears valid bits, counters and sums, and sets capacity to 64.
// Slot contents are not cleared; there is no clearing pass.
module lru_cache_eviction_tracker import lct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [19:0] block_address
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // evicted_address, age_since_reference,
                                                 // age_since_entry, access_total,
                                                 // miss_total, fill_mark, evict_total,
                                                 // age_sum, age_square_sum
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // [0] was_miss, [1] did_evict
);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_SQR, ST_FIN} state_e;

  state_e                state_q;
  logic [CAP_W-1:0]      cap_q;
  logic [OCC_W-1:0]      occ_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [COUNT_BITS-1:0] acc_q, miss_q, fill_q, evc_q;
  logic [SUM_W-1:0]      sum_q, sqsum_q;
  logic                  was_miss_q, did_evict_q;
  logic [ADDR_BITS-1:0]  ev_addr_q;
  logic [COUNT_BITS-1:0] age_ref_q, age_ent_q;
  logic [SQ_W-1:0]       sq_q;
  logic                  m_valid_q;
  lct_out_t              m_data_q;
  logic [OUT_TUSER_W-1:0] m_user_q;

  lct_entry_t            ent [MAX_ENTRIES+2];
  logic [MAX_ENTRIES-1:0] match;
  logic [MAX_ENTRIES:0]  ge;
  lct_ctl_t              ctl;

  logic                  accept, hit, evict, fin_go;
  logic [OCC_W-1:0]      eff_cap, new_occ;
  logic [COUNT_BITS-1:0] acc_inc, hit_enter, age_ref, age_ent;
  lct_entry_t            victim;
  logic [SUM_W-1:0]      sum_nx, sqsum_nx;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // cell chain
  assign ent[MAX_ENTRIES]   = '0;
  assign ent[MAX_ENTRIES+1] = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lct_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(i)),
      .ctl_i      (ctl),
      .ge_self_i  (ge[i]),
      .ge_next_i  (ge[i+1]),
      .nb1_i      (ent[i+1]),
      .nb2_i      (ent[i+2]),
      .entry_o    (ent[i]),
      .match_o    (match[i])
    );
  end

  // prefix OR: ge[j] set when the hit slot is at or below j
  always_comb begin
    logic [MAX_ENTRIES-1:0] p;
    p = match;
    for (int s = 1; s < MAX_ENTRIES; s = s * 2) begin
      p = p | (p << s);
    end
    ge = {p[MAX_ENTRIES-1], p};
  end

  always_comb begin
    hit_enter = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_enter = hit_enter | (match[i] ? ent[i].enter : '0);
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = OCC_W'(1);
    end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
      eff_cap = OCC_W'(MAX_ENTRIES);
    end else begin
      eff_cap = OCC_W'(cap_q);
    end
  end

  always_comb begin
    hit     = |match;
    acc_inc = lct_sat_inc(acc_q);
    evict   = hit ? (occ_q > eff_cap) : (occ_q >= eff_cap);
    new_occ = hit ? (occ_q - OCC_W'(evict)) : (occ_q + 1'b1 - OCC_W'(evict));
    // on a hit at the LRU slot, the old second slot becomes the victim
    victim  = (hit && match[0]) ? ent[1] : ent[0];
    age_ref = evict ? (acc_inc - victim.refs)  : '0;
    age_ent = evict ? (acc_inc - victim.enter) : '0;
  end

  always_comb begin
    ctl             = '0;
    ctl.cmp         = accept;
    ctl.cmp_addr    = ADDR_BITS'(s_axis_tdata[19:0]);
    ctl.upd         = (state_q == ST_UPD);
    ctl.hit         = hit;
    ctl.evict       = evict;
    ctl.top         = IDX_W'(new_occ - 1'b1);
    ctl.fresh.valid = 1'b1;
    ctl.fresh.addr  = addr_q;
    ctl.fresh.enter = hit ? hit_enter : acc_inc;
    ctl.fresh.refs  = acc_inc;
  end

  assign sum_nx   = lct_sat_add(sum_q, SUM_W'(age_ref_q));
  assign sqsum_nx = lct_sat_add(sqsum_q, SUM_W'(sq_q));
  assign fin_go   = (state_q == ST_FIN) && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAP_RESET;
      occ_q       <= '0;
      addr_q      <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      fill_q      <= '0;
      evc_q       <= '0;
      sum_q       <= '0;
      sqsum_q     <= '0;
      was_miss_q  <= 1'b0;
      did_evict_q <= 1'b0;
      ev_addr_q   <= '0;
      age_ref_q   <= '0;
      age_ent_q   <= '0;
      sq_q        <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_user_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // a new result replacing the taken one keeps valid high
      if (m_valid_q && m_axis_tready && !fin_go) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            addr_q  <= ADDR_BITS'(s_axis_tdata[19:0]);
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          acc_q <= acc_inc;
          if (occ_q < eff_cap) begin
            fill_q <= acc_inc;
          end
          if (!hit) begin
            miss_q <= lct_sat_inc(miss_q);
          end
          if (evict) begin
            evc_q <= lct_sat_inc(evc_q);
          end
          occ_q       <= new_occ;
          was_miss_q  <= !hit;
          did_evict_q <= evict;
          ev_addr_q   <= evict ? victim.addr : '0;
          age_ref_q   <= age_ref;
          age_ent_q   <= age_ent;
          state_q     <= ST_SQR;
        end
        ST_SQR: begin
          sq_q    <= age_ref_q * age_ref_q;
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) begin
            sum_q     <= sum_nx;
            sqsum_q   <= sqsum_nx;
            m_valid_q <= 1'b1;
            m_data_q.pad                 <= '0;
            m_data_q.age_square_sum      <= sqsum_nx;
            m_data_q.age_sum             <= sum_nx;
            m_data_q.evict_total         <= 32'(evc_q);
            m_data_q.fill_mark           <= 32'(fill_q);
            m_data_q.miss_total          <= 32'(miss_q);
            m_data_q.access_total        <= 32'(acc_q);
            m_data_q.age_since_entry     <= 32'(age_ent_q);
            m_data_q.age_since_reference <= 32'(age_ref_q);
            m_data_q.evicted_address     <= 20'(ev_addr_q);
            m_user_q  <= {did_evict_q, was_miss_q};
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> sv/lct_cell.sv
// One slot of the recency chain: compare, hold and shift toward the LRU end.
module lct_cell import lct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  lct_ctl_t         ctl_i,
  input  logic             ge_self_i,
  input  logic             ge_next_i,
  input  lct_entry_t       nb1_i,
  input  lct_entry_t       nb2_i,
  output lct_entry_t       entry_o,
  output logic             match_o
);

  logic                  valid_q;
  logic [ADDR_BITS-1:0]  addr_q;
  logic [COUNT_BITS-1:0] enter_q, refs_q;
  lct_entry_t            cur, ent_d;
  logic                  match_q;
  logic [1:0]            sel;
  logic                  past_hit;

  assign cur = {valid_q, addr_q, enter_q, refs_q};

  // slots at or above the hit slide down one extra place
  always_comb begin
    past_hit = ctl_i.evict ? ge_next_i : ge_self_i;
    sel      = {1'b0, ctl_i.evict} + {1'b0, ctl_i.hit & past_hit};
  end

  always_comb begin
    ent_d = cur;
    if (cell_idx_i == ctl_i.top) begin
      ent_d = ctl_i.fresh;
    end else if (cell_idx_i > ctl_i.top) begin
      ent_d.valid = 1'b0;
    end else begin
      case (sel)
        2'd0:    ent_d = cur;
        2'd1:    ent_d = nb1_i;
        2'd2:    ent_d = nb2_i;
        default: ent_d = cur;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      if (ctl_i.cmp) begin
        match_q <= valid_q && (addr_q == ctl_i.cmp_addr);
      end
      if (ctl_i.upd) begin
        valid_q <= ent_d.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      addr_q  <= ent_d.addr;
      enter_q <= ent_d.enter;
      refs_q  <= ent_d.refs;
    end
  end

  assign entry_o = cur;
  assign match_o = match_q;

endmodule

>>> dv/tb_lru_cache_eviction_tracker.sv
// Self-checking testbench for the LRU eviction tracker: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_lru_cache_eviction_tracker;
  import lct_pkg::*;

  // one expected result beat; tuser fields first, then the tdata fields
  typedef struct packed {
    logic        was_miss;
    logic        did_evict;
    logic [19:0] evicted_address;
    logic [31:0] age_since_reference;
    logic [31:0] age_since_entry;
    logic [31:0] access_total;
    logic [31:0] miss_total;
    logic [31:0] fill_mark;
    logic [31:0] evict_total;
    logic [63:0] age_sum;
    logic [63:0] age_square_sum;
  } lru_result_t;

  typedef struct packed {
    logic              wr_cap;
    logic [CAP_W-1:0]  cap;
    logic [19:0]       addr;
    logic              pinned;
    lru_result_t       res;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 110;
  localparam int LONG_HOLD = 300;

  // Rows with pinned results start at capacity 0, which behaves as one entry.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b1, 7'd0, 20'h00000, 1'b1,
      '{1'b1, 1'b0, 20'h00000, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 64'd0, 64'd0}},
    '{1'b0, 7'd0, 20'hFFFFF, 1'b1,
      '{1'b1, 1'b1, 20'h00000, 32'd1, 32'd1, 32'd2, 32'd2, 32'd1, 32'd1, 64'd1, 64'd1}},
    '{1'b0, 7'd0, 20'hFFFFF, 1'b1,
      '{1'b0, 1'b0, 20'h00000, 32'd0, 32'd0, 32'd3, 32'd2, 32'd1, 32'd1, 64'd1, 64'd1}},
    '{1'b0, 7'd0, 20'h00000, 1'b1,
      '{1'b1, 1'b1, 20'hFFFFF, 32'd1, 32'd2, 32'd4, 32'd3, 32'd1, 32'd2, 64'd2, 64'd2}},
    // capacity above the built size, then lowered below occupancy (hit evicts)
    '{1'b1, 7'd127, 20'hAAAAA, 1'b0, '0},
    '{1'b0, 7'd0,   20'h55555, 1'b0, '0},
    '{1'b0, 7'd0,   20'h00000, 1'b0, '0},
    '{1'b0, 7'd0,   20'hAAAAA, 1'b0, '0},
    '{1'b1, 7'd2,   20'h00000, 1'b0, '0},
    '{1'b0, 7'd0,   20'h12345, 1'b0, '0},
    '{1'b1, 7'd1,   20'h12345, 1'b0, '0},
    '{1'b1, 7'd64,  20'h00001, 1'b0, '0},
    '{1'b0, 7'd0,   20'h80000, 1'b0, '0},
    '{1'b0, 7'd0,   20'h7FFFF, 1'b0, '0},
    '{1'b0, 7'd0,   20'hFFFFE, 1'b0, '0},
    '{1'b0, 7'd0,   20'h00001, 1'b0, '0},
    // misses while over capacity drop only one entry each
    '{1'b1, 7'd3,   20'h0F0F0, 1'b0, '0},
    '{1'b0, 7'd0,   20'hF0F0F, 1'b0, '0},
    '{1'b0, 7'd0,   20'h00001, 1'b0, '0},
    '{1'b1, 7'd64,  20'h7FFFF, 1'b0, '0}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  lru_cache_eviction_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // directory mirror, index 0 is least recent
  logic [19:0]      lru_addr  [MAX_ENTRIES];
  logic [31:0]      lru_enter [MAX_ENTRIES];
  logic [31:0]      lru_ref   [MAX_ENTRIES];
  int               lru_occ = 0;
  logic [31:0]      lru_accesses = '0;
  logic [31:0]      lru_misses = '0;
  logic [31:0]      lru_fill = '0;
  logic [31:0]      lru_evicts = '0;
  logic [63:0]      lru_age_sum = '0;
  logic [63:0]      lru_sq_sum = '0;
  logic [CAP_W-1:0] lru_cap_setting = CAP_RESET;

  lru_result_t pending_results [$];
  lru_result_t pin_res = '0;
  logic        pin_on = 1'b0;

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  logic long_hold_go = 1'b0;
  logic hold_active = 1'b0;
  int  mismatches = 0;
  int  cap_writes = 0;

  function automatic lru_result_t lru_access(input logic [19:0] addr);
    lru_result_t r;
    int          eff;
    int          pos;
    logic [31:0] en;
    logic [63:0] sq;
    logic [64:0] acc;
    r = '0;
    eff = (lru_cap_setting == 0) ? 1 :
          ((lru_cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : int'(lru_cap_setting));
    if (lru_accesses != '1) lru_accesses = lru_accesses + 1;
    if (lru_occ < eff) lru_fill = lru_accesses;
    pos = -1;
    for (int i = 0; i < lru_occ; i++) begin
      if (pos < 0 && lru_addr[i] == addr) pos = i;
    end
    r.was_miss = (pos < 0);
    if (pos >= 0) begin
      // hit: move to most recent, keep entry stamp
      en = lru_enter[pos];
      for (int i = pos; i < lru_occ - 1; i++) begin
        lru_addr[i]  = lru_addr[i+1];
        lru_enter[i] = lru_enter[i+1];
        lru_ref[i]   = lru_ref[i+1];
      end
      lru_addr[lru_occ-1]  = addr;
      lru_enter[lru_occ-1] = en;
      lru_ref[lru_occ-1]   = lru_accesses;
    end else if (lru_misses != '1) begin
      lru_misses = lru_misses + 1;
    end
    if (lru_occ + (r.was_miss ? 1 : 0) > eff && lru_occ > 0) begin
      r.did_evict           = 1'b1;
      r.evicted_address     = lru_addr[0];
      r.age_since_reference = lru_accesses - lru_ref[0];
      r.age_since_entry     = lru_accesses - lru_enter[0];
      for (int i = 0; i < lru_occ - 1; i++) begin
        lru_addr[i]  = lru_addr[i+1];
        lru_enter[i] = lru_enter[i+1];
        lru_ref[i]   = lru_ref[i+1];
      end
      lru_occ = lru_occ - 1;
      if (lru_evicts != '1) lru_evicts = lru_evicts + 1;
      acc = {1'b0, lru_age_sum} + {33'b0, r.age_since_reference};
      lru_age_sum = acc[64] ? '1 : acc[63:0];
      sq = {32'b0, r.age_since_reference} * {32'b0, r.age_since_reference};
      acc = {1'b0, lru_sq_sum} + {1'b0, sq};
      lru_sq_sum = acc[64] ? '1 : acc[63:0];
    end
    if (r.was_miss && lru_occ < MAX_ENTRIES) begin
      lru_addr[lru_occ]  = addr;
      lru_enter[lru_occ] = lru_accesses;
      lru_ref[lru_occ]   = lru_accesses;
      lru_occ = lru_occ + 1;
    end
    r.access_total   = lru_accesses;
    r.miss_total     = lru_misses;
    r.fill_mark      = lru_fill;
    r.evict_total    = lru_evicts;
    r.age_sum        = lru_age_sum;
    r.age_square_sum = lru_sq_sum;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // predict on each accepted access, check each accepted result beat
  always @(posedge clk_i) begin : beat_monitor
    lru_result_t want;
    lct_out_t    got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = lru_access(s_axis_tdata[19:0]);
        if (pin_on) want = pin_res;
        pending_results.insert(pending_results.size(), want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with no access pending", $time);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          got  = lct_out_t'(m_axis_tdata);
          check_field("was_miss", 64'(want.was_miss), 64'(m_axis_tuser[0]));
          check_field("did_evict", 64'(want.did_evict), 64'(m_axis_tuser[1]));
          check_field("evicted_address", 64'(want.evicted_address),
                      64'(got.evicted_address));
          check_field("age_since_reference", 64'(want.age_since_reference),
                      64'(got.age_since_reference));
          check_field("age_since_entry", 64'(want.age_since_entry),
                      64'(got.age_since_entry));
          check_field("access_total", 64'(want.access_total), 64'(got.access_total));
          check_field("miss_total", 64'(want.miss_total), 64'(got.miss_total));
          check_field("fill_mark", 64'(want.fill_mark), 64'(got.fill_mark));
          check_field("evict_total", 64'(want.evict_total), 64'(got.evict_total));
          check_field("age_sum", want.age_sum, got.age_sum);
          check_field("age_square_sum", want.age_square_sum, got.age_square_sum);
        end
      end
    end
  end

  always @(posedge clk_i)
    m_axis_tready <= rst_ni && !hold_active && ($urandom_range(99) >= rx_idle_pct);

  // long back-pressure so the block fills and stalls its input
  initial begin
    int held;
    wait (long_hold_go);
    @(posedge clk_i);
    hold_active <= 1'b1;
    for (held = 0; held < LONG_HOLD; held++) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic offer_address(input logic [19:0] a);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-20){1'b0}}, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lru_cap_setting = v;
    cap_writes++;
  endtask

  initial begin
    int               eff;
    int               pool_n;
    logic [CAP_W-1:0] cap;
    logic [19:0]      pool [$];
    logic [19:0]      a;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].wr_cap) begin
        drain_results();
        write_capacity(DIR_TABLE[r].cap);
      end
      pin_on  <= DIR_TABLE[r].pinned;
      pin_res <= DIR_TABLE[r].res;
      offer_address(DIR_TABLE[r].addr);
    end
    pin_on <= 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      tx_idle_pct = (ph < 4) ? 8 : ((ph < 8) ? 65 : 0);
      rx_idle_pct = (ph < 4) ? 65 : ((ph < 8) ? 8 : 0);
      case (ph % 4)
        0:       cap = 7'd1;
        1:       cap = 7'd64;
        2:       cap = 7'd127;
        default: cap = CAP_W'($urandom_range(0, 127));
      endcase
      drain_results();
      write_capacity(cap);
      eff = (cap == 0) ? 1 : ((cap > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap));
      // working set a bit around the capacity: mix of hits and evictions
      pool.delete();
      pool_n = $urandom_range(eff / 2 + 1, eff + eff / 3 + 2);
      repeat (pool_n) pool.insert(pool.size(), 20'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 9 && k == 10) long_hold_go = 1'b1;
        if ($urandom_range(99) < 85) a = pool[$urandom_range(pool.size() - 1)];
        else a = 20'($urandom);
        offer_address(a);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d accesses: %0d misses, %0d evictions, %0d capacity writes,",
             lru_accesses, lru_misses, lru_evicts, cap_writes);
    $display("with stalls on both sides and one long result hold-off.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
